>>> design/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked in reset
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> design/cltl_pkg.sv
package cltl_pkg;

    localparam int unsigned CutDepthDef    = 64;
    localparam int unsigned MarkerDepthDef = 64;
    localparam logic [15:0] BackSkipReset  = 16'd5000;
    localparam logic [31:0] TimeMax        = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_ADD_CUT    = 3'd0,
        OP_ADD_MARKER = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_RESTORE    = 3'd3,
        OP_IN_CUT     = 3'd4,
        OP_MARKER     = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NOP        = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        LS_NONE    = 2'd0,
        LS_BOTH    = 2'd1,
        LS_CUTS    = 2'd2,
        LS_MARKERS = 2'd3
    } t_list_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] start_or_time;
        logic [31:0] end_time;
        logic        cut_kind;
        logic        direction;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] time_out;
        logic        hit_kind;
        logic [31:0] total_cut_ms;
        logic [1:0]  list_status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUT_SCAN,   // overlap check and insert position
        ST_SHIFT,      // move entries up one slot
        ST_WRITE,
        ST_MK_SCAN,    // marker-in-cut check
        ST_SUM,        // remove / restore accumulation, also marker restore
        ST_INCUT,
        ST_MSEARCH,    // nearest marker walk
        ST_MCHECK,     // found marker in cut check
        ST_DONE
    } t_state;

endpackage

>>> design/cut_list_timeline_engine_core.sv
// Cut-list timeline engine. One operation per input beat, one result beat
// per operation. The sequencer walks the cut table or marker store one entry
// per cycle through a memory with one write port and one registered read
// port. Add cut walks the table and then shifts every entry above the
// insert point, reading and then writing each one. Marker search restores
// the clock over the cuts, walks the markers and then checks the found
// marker against the cuts. Clear and no-op go straight to the result. Ready
// is low while an item is in flight and comes back together with
// o_out_valid. A result that is not yet taken holds in the output register;
// the next item may be accepted meanwhile and waits in its last state until
// the register is free. The back_skip_ms register is written via the config
// channel while idle; an input beat yields to a config beat offered in the
// same cycle.
module cut_list_timeline_engine_core #(
    parameter int unsigned CUT_DEPTH    = cltl_pkg::CutDepthDef,
    parameter int unsigned MARKER_DEPTH = cltl_pkg::MarkerDepthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cltl_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cltl_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);
    import cltl_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned CAW = (CUT_DEPTH > 1) ? $clog2(CUT_DEPTH) : 1;
    localparam int unsigned MAW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
    localparam int unsigned CCW = $clog2(CUT_DEPTH + 1);
    localparam int unsigned MCW = $clog2(MARKER_DEPTH + 1);
    localparam int unsigned IW  = (CCW > MCW) ? CCW : MCW;

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [CCW-1:0] r_ccnt, n_ccnt;     // cut count
    logic [MCW-1:0] r_mcnt, n_mcnt;     // marker count
    logic [31:0] r_total, n_total;
    logic [15:0] r_skip;
    logic [IW-1:0] r_idx, n_idx;        // walk index (issued address)
    logic        r_vld, n_vld;          // read data of previous address valid
    logic [CCW-1:0] r_pos, n_pos;       // insert position
    logic        r_posf, n_posf;
    logic [32:0] r_acc, n_acc;          // shared accumulator
    logic [31:0] r_seek, n_seek;
    logic        r_have, n_have;
    logic        r_ok, n_ok;
    logic        r_hk, n_hk;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    // memory ports
    logic           c_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [64:0]    c_wdata, c_rdata;
    logic           m_we;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [31:0]    m_wdata, m_rdata;

    cltl_cut_mem #(.DEPTH(CUT_DEPTH), .AW(CAW)) u_cut (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    cltl_mk_mem #(.DEPTH(MARKER_DEPTH), .AW(MAW)) u_mk (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    logic [31:0] rd_s, rd_e;
    logic        rd_k;
    assign rd_s = c_rdata[31:0];
    assign rd_e = c_rdata[63:32];
    assign rd_k = c_rdata[64];

    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ccnt   <= '0;
            r_mcnt   <= '0;
            r_total  <= '0;
            r_skip   <= BackSkipReset;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ccnt   <= n_ccnt;
            r_mcnt   <= n_mcnt;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_skip <= i_cfg_data;
            end
        end
        r_item <= n_item;
        r_idx  <= n_idx;
        r_vld  <= n_vld;
        r_pos  <= n_pos;
        r_posf <= n_posf;
        r_acc  <= n_acc;
        r_seek <= n_seek;
        r_have <= n_have;
        r_ok   <= n_ok;
        r_hk   <= n_hk;
        r_out  <= n_out;
    end

    logic [31:0] t_s, t_e;
    logic [32:0] diff_new;
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_ccnt   = r_ccnt;
        n_mcnt   = r_mcnt;
        n_total  = r_total;
        n_idx    = r_idx;
        n_vld    = 1'b0;
        n_pos    = r_pos;
        n_posf   = r_posf;
        n_acc    = r_acc;
        n_seek   = r_seek;
        n_have   = r_have;
        n_ok     = r_ok;
        n_hk     = r_hk;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        c_we     = 1'b0;
        c_waddr  = r_idx[CAW-1:0];
        c_wdata  = c_rdata;
        c_raddr  = r_idx[CAW-1:0];
        m_we     = 1'b0;
        m_waddr  = r_mcnt[MAW-1:0];
        m_wdata  = r_item.start_or_time;
        m_raddr  = r_idx[MAW-1:0];
        t_s      = r_item.start_or_time;
        t_e      = r_item.end_time;
        diff_new = '0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    n_ok   = 1'b1;
                    n_hk   = 1'b0;
                    n_acc  = {1'b0, i_in_data.start_or_time};
                    n_have = 1'b0;
                    n_posf = 1'b0;
                    n_pos  = r_ccnt;
                    unique case (t_op'(i_in_data.opcode))
                        OP_ADD_CUT: begin
                            if (i_in_data.start_or_time >= i_in_data.end_time ||
                                r_ccnt == CCW'(CUT_DEPTH)) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_CUT_SCAN;
                            end
                        end
                        OP_ADD_MARKER: begin
                            if (r_mcnt == MCW'(MARKER_DEPTH)) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_MK_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            n_acc   = '0;
                            n_state = ST_SUM;
                        end
                        OP_RESTORE: n_state = ST_SUM;
                        OP_IN_CUT:  n_state = ST_INCUT;
                        OP_MARKER: begin
                            if (r_ccnt == '0) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SUM;
                            end
                        end
                        OP_CLEAR: begin
                            n_ccnt  = '0;
                            n_mcnt  = '0;
                            n_total = '0;
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                    n_vld = 1'b0;
                end
            end

            // entry r_idx-1 is in c_rdata when r_vld
            ST_CUT_SCAN: begin
                if (r_vld) begin
                    if ((rd_s <= t_s && rd_e >= t_s) || (rd_s <= t_e && rd_e >= t_e) ||
                        (t_s < rd_s && t_e > rd_e)) begin
                        n_ok    = 1'b0;
                        n_state = ST_DONE;
                    end
                    if (!r_posf && rd_s > t_s) begin
                        n_posf = 1'b1;
                        n_pos  = CCW'(r_idx - 1'b1);
                    end
                end
                if (n_state == ST_CUT_SCAN) begin
                    if (r_idx == IW'(r_ccnt)) begin
                        if (r_vld || r_ccnt == '0) begin
                            n_idx   = IW'(r_ccnt);
                            n_state = ST_SHIFT;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_vld = 1'b1;
                    end
                end
            end

            // r_idx is the destination; read idx-1, write next cycle
            ST_SHIFT: begin
                if (r_idx == IW'(r_pos)) begin
                    n_state = ST_WRITE;
                end else if (!r_vld) begin
                    c_raddr = CAW'(r_idx - 1'b1);
                    n_vld   = 1'b1;
                end else begin
                    c_we    = 1'b1;
                    c_waddr = r_idx[CAW-1:0];
                    n_idx   = r_idx - 1'b1;
                end
            end

            ST_WRITE: begin
                c_we    = 1'b1;
                c_waddr = r_pos[CAW-1:0];
                c_wdata = {r_item.cut_kind, t_e, t_s};
                n_ccnt  = r_ccnt + 1'b1;
                if (!r_item.cut_kind) begin
                    n_total = r_total + (t_e - t_s);
                end
                n_state = ST_DONE;
            end

            // walk cuts: sorted first-hit search on r_seek or item time
            ST_MK_SCAN, ST_INCUT, ST_MCHECK: begin
                if (r_state == ST_MCHECK) begin
                    t_s = r_seek;
                end
                if (r_vld) begin
                    if (rd_s <= t_s && rd_e >= t_s) begin
                        if (r_state == ST_INCUT) begin
                            n_hk = rd_k;
                        end else if (!rd_k) begin
                            n_ok = 1'b0;
                        end else begin
                            n_ok = r_ok;
                        end
                        if (r_state == ST_MCHECK && n_ok) begin
                            n_acc = {1'b0, r_seek};
                        end
                        n_state = ST_DONE;
                    end else if (rd_s > t_s) begin
                        n_state = ST_DONE;
                        if (r_state == ST_INCUT) begin
                            n_ok = 1'b0;
                        end
                        if (r_state == ST_MCHECK) begin
                            n_acc = {1'b0, r_seek};
                        end
                    end
                end
                if (n_state == r_state) begin
                    if (r_idx == IW'(r_ccnt)) begin
                        if (r_vld || r_ccnt == '0) begin
                            n_state = ST_DONE;
                            if (r_state == ST_INCUT) begin
                                n_ok = 1'b0;
                            end
                            if (r_state == ST_MCHECK) begin
                                n_acc = {1'b0, r_seek};
                            end
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_vld = 1'b1;
                    end
                end
                if (n_state == ST_DONE && r_state == ST_MK_SCAN && n_ok) begin
                    m_we   = 1'b1;
                    n_mcnt = r_mcnt + 1'b1;
                end
            end

            // remove: acc sums lengths; restore/marker: acc grows
            ST_SUM: begin
                if (r_vld && !rd_k) begin
                    if (t_op'(r_item.opcode) == OP_REMOVE) begin
                        if (rd_e <= t_s) begin
                            n_acc = 33'(r_acc[31:0] + (rd_e - rd_s));
                        end
                    end else if ({1'b0, rd_s} <= r_acc) begin
                        n_acc = r_acc + {1'b0, rd_e - rd_s};
                    end
                end
                if (r_idx == IW'(r_ccnt)) begin
                    if (r_vld || r_ccnt == '0) begin
                        if (t_op'(r_item.opcode) == OP_REMOVE) begin
                            n_acc = (n_acc[31:0] <= t_s) ? {1'b0, t_s - n_acc[31:0]} : '0;
                            n_state = ST_DONE;
                        end else begin
                            if (n_acc[32]) begin
                                n_acc = {1'b0, TimeMax};
                            end
                            if (t_op'(r_item.opcode) == OP_MARKER) begin
                                n_seek = n_acc[31:0];
                                if (!r_item.direction) begin
                                    n_seek = (n_acc[31:0] > {16'd0, r_skip}) ?
                                             n_acc[31:0] - {16'd0, r_skip} : '0;
                                end
                                n_idx   = '0;
                                n_state = ST_MSEARCH;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_vld = 1'b1;
                end
            end

            // acc holds best diff, r_seek target until done; best in r_item.end_time
            ST_MSEARCH: begin
                if (r_vld) begin
                    if (r_item.direction) begin
                        diff_new = {1'b0, m_rdata - r_seek};
                        if (m_rdata > r_seek && (!r_have || diff_new < r_acc)) begin
                            n_acc = diff_new;
                            n_have = 1'b1;
                            n_item.end_time = m_rdata;
                        end
                    end else begin
                        diff_new = {1'b0, r_seek - m_rdata};
                        if (m_rdata < r_seek && (!r_have || diff_new < r_acc)) begin
                            n_acc = diff_new;
                            n_have = 1'b1;
                            n_item.end_time = m_rdata;
                        end
                    end
                end
                if (r_idx == '0 && r_mcnt == '0 ||
                    (r_idx == IW'(r_mcnt) && r_vld)) begin
                    if (!n_have) begin
                        n_ok    = 1'b0;
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_seek  = n_item.end_time;
                        n_idx   = '0;
                        n_state = ST_MCHECK;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_vld = 1'b1;
                end
            end

            ST_DONE: begin
                if (!r_ovalid) begin
                    n_out.ok       = r_ok;
                    n_out.time_out = 32'd0;
                    if (r_ok && (t_op'(r_item.opcode) == OP_REMOVE ||
                                 t_op'(r_item.opcode) == OP_RESTORE ||
                                 t_op'(r_item.opcode) == OP_MARKER)) begin
                        n_out.time_out = r_acc[31:0];
                    end
                    n_out.hit_kind     = (t_op'(r_item.opcode) == OP_IN_CUT) ? r_hk : 1'b0;
                    n_out.total_cut_ms = (r_ccnt != '0) ? r_total : 32'd0;
                    if (r_ccnt != '0 && r_mcnt != '0) begin
                        n_out.list_status = LS_BOTH;
                    end else if (r_ccnt != '0) begin
                        n_out.list_status = LS_CUTS;
                    end else if (r_mcnt != '0) begin
                        n_out.list_status = LS_MARKERS;
                    end else begin
                        n_out.list_status = LS_NONE;
                    end
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_ccnt <= CCW'(CUT_DEPTH))
    `ASSERT_IMPL(a_mcnt_range, i_clk, i_rst_n, 1'b1, r_mcnt <= MCW'(MARKER_DEPTH))
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

>>> design/cltl_cut_mem.sv
module cltl_cut_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [64:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [64:0]   o_rdata
);
    // {kind, end, start}; one write and one registered read per cycle
    logic [64:0] r_mem [DEPTH];
    logic [64:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/cltl_mk_mem.sv
module cltl_mk_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> bench/tb_cut_list_timeline_engine_core.sv
`timescale 1ns / 100ps

module tb_cut_list_timeline_engine_core;
    import cltl_pkg::*;

    localparam int unsigned NCUT = CutDepthDef;
    localparam int unsigned NMARK = MarkerDepthDef;
    localparam int unsigned STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    cut_list_timeline_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Shadow of the block's timeline state
    logic [31:0] sh_start [NCUT];
    logic [31:0] sh_end [NCUT];
    logic        sh_kind [NCUT];
    int unsigned sh_ncut;
    logic [31:0] sh_total;
    logic [31:0] sh_mark [NMARK];
    int unsigned sh_nmark;
    logic [15:0] sh_back_skip;

    t_in_item  beat_q [$];      // beats waiting to be driven
    t_out_item result_q [$];    // predicted results, oldest first
    int unsigned fails;
    int unsigned idle_cycles;
    bit          hold_send;     // sender paused by the stimulus thread

    function automatic void queue_beat(input t_in_item it);
        beat_q.insert(beat_q.size(), it);
    endfunction

    // First interval holding t, table walked in start order
    function automatic bit cut_lookup(input logic [31:0] t, output logic k);
        k = 1'b0;
        for (int i = 0; i < sh_ncut; i++) begin
            if (sh_start[i] <= t && sh_end[i] >= t) begin
                k = sh_kind[i];
                return 1'b1;
            end
            if (sh_start[i] > t) return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic bit in_real_cut(input logic [31:0] t);
        logic k;
        return cut_lookup(t, k) && k == 1'b0;
    endfunction

    function automatic logic [31:0] restored(input logic [31:0] t);
        logic [32:0] acc;
        acc = {1'b0, t};
        for (int i = 0; i < sh_ncut; i++)
            if (!sh_kind[i] && {1'b0, sh_start[i]} <= acc)
                acc += {1'b0, sh_end[i] - sh_start[i]};
        return acc[32] ? TimeMax : acc[31:0];
    endfunction

    function automatic logic [31:0] removed(input logic [31:0] t);
        logic [31:0] sum;
        sum = '0;
        for (int i = 0; i < sh_ncut; i++)
            if (!sh_kind[i] && sh_end[i] <= t) sum += sh_end[i] - sh_start[i];
        return (sum <= t) ? t - sum : 32'd0;
    endfunction

    function automatic bit try_insert(input logic [31:0] s, input logic [31:0] e,
                                      input logic k);
        int unsigned pos;
        logic dk;
        if (s >= e || sh_ncut >= NCUT) return 1'b0;
        if (cut_lookup(s, dk) || cut_lookup(e, dk)) return 1'b0;
        for (int i = 0; i < sh_ncut; i++)
            if (s < sh_start[i] && e > sh_end[i]) return 1'b0;
        pos = sh_ncut;
        for (int i = 0; i < sh_ncut; i++)
            if (sh_start[i] > s) begin
                pos = i;
                break;
            end
        for (int i = sh_ncut; i > pos; i--) begin
            sh_start[i] = sh_start[i-1];
            sh_end[i] = sh_end[i-1];
            sh_kind[i] = sh_kind[i-1];
        end
        sh_start[pos] = s;
        sh_end[pos] = e;
        sh_kind[pos] = k;
        sh_ncut++;
        if (!k) sh_total += e - s;
        return 1'b1;
    endfunction

    function automatic bit seek_marker(input logic dir, input logic [31:0] clk_ms,
                                       output logic [31:0] found);
        logic [31:0] seek, best, diff;
        bit have;
        found = '0;
        best = '0;
        diff = '0;
        have = 0;
        if (sh_ncut == 0) return 1'b0;
        seek = restored(clk_ms);
        if (dir) begin
            for (int i = 0; i < sh_nmark; i++)
                if (sh_mark[i] > seek && (!have || sh_mark[i] - seek < diff)) begin
                    diff = sh_mark[i] - seek;
                    best = sh_mark[i];
                    have = 1;
                end
        end else begin
            seek = (seek > {16'd0, sh_back_skip}) ? seek - sh_back_skip : 32'd0;
            for (int i = 0; i < sh_nmark; i++)
                if (sh_mark[i] < seek && (!have || seek - sh_mark[i] < diff)) begin
                    diff = seek - sh_mark[i];
                    best = sh_mark[i];
                    have = 1;
                end
        end
        if (!have || in_real_cut(best)) return 1'b0;
        found = best;
        return 1'b1;
    endfunction

    // Apply one accepted beat to the shadow state and queue its result
    function automatic void timeline_apply(input t_in_item it);
        t_out_item r;
        logic k;
        logic [31:0] m;
        r = '0;
        r.ok = 1'b1;
        case (t_op'(it.opcode))
            OP_ADD_CUT:
                r.ok = try_insert(it.start_or_time, it.end_time, it.cut_kind);
            OP_ADD_MARKER:
                if (sh_nmark >= NMARK || in_real_cut(it.start_or_time)) r.ok = 1'b0;
                else begin
                    sh_mark[sh_nmark] = it.start_or_time;
                    sh_nmark++;
                end
            OP_REMOVE:  r.time_out = removed(it.start_or_time);
            OP_RESTORE: r.time_out = restored(it.start_or_time);
            OP_IN_CUT: begin
                r.ok = cut_lookup(it.start_or_time, k);
                r.hit_kind = r.ok ? k : 1'b0;
            end
            OP_MARKER: begin
                r.ok = seek_marker(it.direction, it.start_or_time, m);
                r.time_out = m;
            end
            OP_CLEAR: begin
                sh_ncut = 0;
                sh_nmark = 0;
                sh_total = '0;
            end
            default: ;
        endcase
        r.total_cut_ms = sh_ncut ? sh_total : 32'd0;
        if (sh_ncut && sh_nmark) r.list_status = LS_BOTH;
        else if (sh_ncut) r.list_status = LS_CUTS;
        else if (sh_nmark) r.list_status = LS_MARKERS;
        else r.list_status = LS_NONE;
        result_q.insert(result_q.size(), r);
    endfunction

    // Driver: bursts of random length, random gaps between them
    int unsigned burst_left;
    int unsigned gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            automatic bit fire = i_in_valid && o_in_ready;
            if (fire) timeline_apply(i_in_data);
            if (!i_in_valid || fire) begin
                if (beat_q.size() != 0 && !hold_send && gap_left == 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= beat_q.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                    end else burst_left <= burst_left - 1;
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left != 0) gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern: long clean stretches, then a busy window
    int unsigned stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[11:10] == 2'b00) i_out_ready <= 1'b1;
            else if (stall_phase[11:10] == 2'b01) i_out_ready <= ($urandom_range(0, 7) == 0);
            else i_out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Monitor: compare each result beat to the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out_data);
                fails++;
            end else begin
                automatic t_out_item w = result_q.pop_front();
                if (w.ok !== o_out_data.ok)
                    $display("%0t: ok expected %0d actual %0d", $time, w.ok, o_out_data.ok);
                if (w.time_out !== o_out_data.time_out)
                    $display("%0t: time_out expected %0d actual %0d", $time,
                             w.time_out, o_out_data.time_out);
                if (w.hit_kind !== o_out_data.hit_kind)
                    $display("%0t: hit_kind expected %0d actual %0d", $time,
                             w.hit_kind, o_out_data.hit_kind);
                if (w.total_cut_ms !== o_out_data.total_cut_ms)
                    $display("%0t: total_cut_ms expected %0d actual %0d", $time,
                             w.total_cut_ms, o_out_data.total_cut_ms);
                if (w.list_status !== o_out_data.list_status)
                    $display("%0t: list_status expected %0d actual %0d", $time,
                             w.list_status, o_out_data.list_status);
                if (w !== o_out_data) fails++;
            end
        end
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in_item mk(input t_op op, input logic [31:0] a,
                                     input logic [31:0] b, input int unsigned k,
                                     input int unsigned d);
        t_in_item it;
        it.opcode = op;
        it.start_or_time = a;
        it.end_time = b;
        it.cut_kind = k[0];
        it.direction = d[0];
        return it;
    endfunction

    // Times cluster in a small window so cuts, markers and queries interact
    function automatic logic [31:0] near_ms();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return TimeMax - $urandom_range(0, 3000);
            default: return $urandom_range(0, 200000);
        endcase
    endfunction

    function automatic t_in_item rand_beat();
        logic [31:0] s;
        int unsigned pick;
        s = near_ms();
        pick = $urandom_range(0, 99);
        if (pick < 28)
            return mk(OP_ADD_CUT, s, s + $urandom_range(0, 6000) - ($urandom_range(0, 9) == 0),
                      $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 46) return mk(OP_ADD_MARKER, s, $urandom, $urandom_range(0, 1),
                                 $urandom_range(0, 1));
        if (pick < 56) return mk(OP_REMOVE, s, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 66) return mk(OP_RESTORE, s, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 78) return mk(OP_IN_CUT, s, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 96) return mk(OP_MARKER, s, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 98) return mk(OP_CLEAR, s, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        return mk(OP_NOP, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // Let everything queued drain, then allow the block to settle
    task automatic drain_all();
        while (beat_q.size() != 0 || i_in_valid || result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_back_skip(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sh_back_skip = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] skips [4];
        skips = '{16'd0, 16'hFFFF, 16'd1234, 16'd5000};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        hold_send = 0;
        fails = 0;
        idle_cycles = 0;
        sh_ncut = 0;
        sh_nmark = 0;
        sh_total = '0;
        sh_back_skip = BackSkipReset;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tables, extremes, overlap and containment rejects
        queue_beat(mk(OP_MARKER, 32'd100, 0, 0, 1));          // no cuts
        queue_beat(mk(OP_REMOVE, TimeMax, 0, 0, 0));
        queue_beat(mk(OP_RESTORE, TimeMax, 0, 0, 0));
        queue_beat(mk(OP_ADD_CUT, 32'd500, 32'd500, 0, 0));   // empty interval
        queue_beat(mk(OP_ADD_CUT, 32'd1000, 32'd2000, 0, 0));
        queue_beat(mk(OP_ADD_CUT, 32'd2000, 32'd2500, 0, 0)); // touches inclusive end
        queue_beat(mk(OP_ADD_CUT, 32'd500, 32'd3000, 1, 0));  // contains a cut
        queue_beat(mk(OP_ADD_CUT, 32'd5000, 32'd6000, 1, 1)); // mute
        queue_beat(mk(OP_ADD_CUT, 32'd0, 32'd10, 0, 0));
        queue_beat(mk(OP_ADD_CUT, 32'hFFFF_F000, TimeMax, 0, 0));
        queue_beat(mk(OP_ADD_MARKER, 32'd1500, 0, 0, 0));     // inside a cut
        queue_beat(mk(OP_ADD_MARKER, 32'd5500, 0, 0, 0));     // inside a mute
        queue_beat(mk(OP_ADD_MARKER, 32'd9000, 0, 0, 0));
        queue_beat(mk(OP_ADD_MARKER, 32'd9000, 0, 0, 0));     // tie
        queue_beat(mk(OP_ADD_MARKER, 32'd0, 0, 0, 0));
        queue_beat(mk(OP_IN_CUT, 32'd2000, 0, 0, 0));
        queue_beat(mk(OP_IN_CUT, 32'd5000, 0, 0, 0));
        queue_beat(mk(OP_IN_CUT, 32'd3000, 0, 0, 0));
        queue_beat(mk(OP_REMOVE, 32'd7000, 0, 0, 0));
        queue_beat(mk(OP_RESTORE, 32'hFFFF_FF00, 0, 0, 0));   // saturates
        queue_beat(mk(OP_MARKER, 32'd3000, 0, 0, 1));
        queue_beat(mk(OP_MARKER, 32'd20000, 0, 0, 0));
        queue_beat(mk(OP_MARKER, TimeMax, TimeMax, 1, 1));
        queue_beat(mk(OP_NOP, TimeMax, TimeMax, 1, 1));
        queue_beat(mk(OP_CLEAR, 0, 0, 0, 0));
        drain_all();

        // Random phases, each under its own back_skip setting
        foreach (skips[p]) begin
            write_back_skip(skips[p]);
            for (int n = 0; n < 350; n++) begin
                queue_beat(rand_beat());
                // mid-phase: hold the sender until every result is back
                if (n == 175) begin
                    while (beat_q.size() != 0 || i_in_valid) @(posedge i_clk);
                    hold_send = 1;
                    while (result_q.size() != 0) @(posedge i_clk);
                    hold_send = 0;
                end
            end
            // fill both stores to capacity in the second phase
            if (p == 1) begin
                for (int n = 0; n < 70; n++) begin
                    queue_beat(mk(OP_ADD_CUT, 32'd1000000 + n * 100,
                                  32'd1000000 + n * 100 + 50, n % 2, 0));
                    queue_beat(mk(OP_ADD_MARKER, 32'd2000000 + n, 0, 0, 0));
                end
                queue_beat(mk(OP_MARKER, 32'd1000000, 0, 0, 1));
                queue_beat(mk(OP_MARKER, 32'd3000000, 0, 0, 0));
            end
            drain_all();
        end

        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
